// ===== rtl/sacl_pkg.sv =====
// Shared types and constants for the set-associative LRU cache.
`timescale 1ns / 1ps
package sacl_pkg;

  localparam int NUM_SETS   = 16;
  localparam int WAYS       = 4;
  localparam int LINE_WORDS = 16;
  localparam int MEM_WORDS  = 4096;

  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(MEM_WORDS);
  localparam int OFF_W   = $clog2(LINE_WORDS);
  localparam int SET_W   = $clog2(NUM_SETS);
  localparam int WAY_W   = $clog2(WAYS);
  localparam int TAG_W   = ADDR_W - SET_W - OFF_W;
  localparam int NLINES  = NUM_SETS * WAYS;
  localparam int DADDR_W = SET_W + WAY_W + OFF_W;
  localparam int CNT_W   = OFF_W + 1;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOKUP,
    ST_WB,
    ST_FILL,
    ST_ACCESS,
    ST_RESP
  } state_e;

  // lookup result of the addressed set
  typedef struct packed {
    logic             hit;
    logic [WAY_W-1:0] way;
    logic             evict;
    logic             dirty_victim;
    logic [TAG_W-1:0] victim_tag;
  } lookup_t;

  // tag/state update request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic             fill;
    logic             mark_dirty;
    logic             touch;
    logic [SET_W-1:0] set;
    logic [WAY_W-1:0] way;
    logic [TAG_W-1:0] tag;
  } tag_ctl_t;

endpackage

// ===== rtl/sacl_if.sv =====
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface sacl_req_if;
  import sacl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [ADDR_W-1:0]     word_address;
  logic [DATA_W-1:0]     write_data;
  modport source (output valid, operation, word_address, write_data, input ready);
  modport sink (input valid, operation, word_address, write_data, output ready);
endinterface

interface sacl_rsp_if;
  import sacl_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              hit;
  logic              evicted;
  logic              wrote_back;
  logic [WAY_W-1:0]  way_used;
  modport source (output valid, read_data, hit, evicted, wrote_back, way_used, input ready);
  modport sink (input valid, read_data, hit, evicted, wrote_back, way_used, output ready);
endinterface

// ===== rtl/sacl_tags.sv =====
// Tag memory, valid/dirty bits and per-set LRU order with hit/victim lookup.
`timescale 1ns / 1ps
module sacl_tags
  import sacl_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tag_ctl_t ctl_i,
  output lookup_t  lkp_o
);

  logic [WAYS*TAG_W-1:0] tag_mem [NUM_SETS];
  logic [WAYS*TAG_W-1:0] row_q;
  logic [WAYS*TAG_W-1:0] row_new;

  logic [NUM_SETS-1:0][WAYS-1:0]            valid_q, valid_d;
  logic [NUM_SETS-1:0][WAYS-1:0]            dirty_q, dirty_d;
  logic [NUM_SETS-1:0][WAYS-1:0][WAY_W-1:0] lru_q, lru_d;

  // one row of tags per set; read at accept, rewritten on fill
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      row_q <= tag_mem[ctl_i.set];
    end
    if (ctl_i.fill) begin
      tag_mem[ctl_i.set] <= row_new;
    end
  end

  always_comb begin
    row_new = row_q;
    row_new[ctl_i.way*TAG_W +: TAG_W] = ctl_i.tag;
  end

  always_comb begin
    logic             found;
    logic             free;
    logic [WAY_W-1:0] hit_way;
    logic [WAY_W-1:0] free_way;
    logic [WAY_W-1:0] way;
    found    = 1'b0;
    free     = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && valid_q[ctl_i.set][w] &&
          row_q[w*TAG_W +: TAG_W] == ctl_i.tag) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!free && !valid_q[ctl_i.set][w]) begin
        free     = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    if (found) begin
      way = hit_way;
    end else if (free) begin
      way = free_way;
    end else begin
      way = lru_q[ctl_i.set][WAYS-1];
    end
    lkp_o.hit          = found;
    lkp_o.way          = way;
    lkp_o.evict        = !found && valid_q[ctl_i.set][way];
    lkp_o.dirty_victim = !found && valid_q[ctl_i.set][way] && dirty_q[ctl_i.set][way];
    lkp_o.victim_tag   = row_q[way*TAG_W +: TAG_W];
  end

  always_comb begin
    int unsigned pos;
    valid_d = valid_q;
    dirty_d = dirty_q;
    lru_d   = lru_q;
    pos     = WAYS - 1;
    if (ctl_i.fill) begin
      valid_d[ctl_i.set][ctl_i.way] = 1'b1;
      dirty_d[ctl_i.set][ctl_i.way] = 1'b0;
    end
    if (ctl_i.mark_dirty) begin
      dirty_d[ctl_i.set][ctl_i.way] = 1'b1;
    end
    if (ctl_i.touch) begin
      for (int i = WAYS - 1; i >= 0; i--) begin
        if (lru_q[ctl_i.set][i] == ctl_i.way) begin
          pos = i;
        end
      end
      for (int i = 1; i < WAYS; i++) begin
        if (i <= pos) begin
          lru_d[ctl_i.set][i] = lru_q[ctl_i.set][i-1];
        end
      end
      lru_d[ctl_i.set][0] = ctl_i.way;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          lru_q[s][w] <= WAY_W'(w);
        end
      end
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
      lru_q   <= lru_d;
    end
  end

endmodule

// ===== rtl/sacl_core.sv =====
// Sequencer with line data memory, backing memory and result register.
`timescale 1ns / 1ps
module sacl_core
  import sacl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  sacl_req_if.sink          req_i,
  sacl_rsp_if.source        rsp_o,
  input  lookup_t           lkp_i,
  output tag_ctl_t          ctl_o
);

  state_e state_q, state_d;

  logic              wt_q;
  logic              op_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  logic [OFF_W-1:0]  off_q;
  logic [DATA_W-1:0] wdata_q;
  logic              hit_q, evict_q, wb_q;
  logic [WAY_W-1:0]  way_q;
  logic [TAG_W-1:0]  vtag_q;
  logic              lkp_en;
  logic              take;

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] init_q, init_d;

  // line data memory
  logic [DATA_W-1:0]  line_mem [NLINES*LINE_WORDS];
  logic               d_we, d_re;
  logic [DADDR_W-1:0] d_waddr, d_raddr;
  logic [DATA_W-1:0]  d_wdata, d_rdata_q;

  // backing memory
  logic [DATA_W-1:0] back_mem [MEM_WORDS];
  logic              m_we, m_re;
  logic [ADDR_W-1:0] m_waddr, m_raddr;
  logic [DATA_W-1:0] m_wdata, m_rdata_q;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [DATA_W-1:0] out_data_q;
  logic              out_hit_q, out_evict_q, out_wb_q;
  logic [WAY_W-1:0]  out_way_q;

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      line_mem[d_waddr] <= d_wdata;
    end
    if (d_re) begin
      d_rdata_q <= line_mem[d_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      back_mem[m_waddr] <= m_wdata;
    end
    if (m_re) begin
      m_rdata_q <= back_mem[m_raddr];
    end
  end

  assign take   = req_i.valid && req_i.ready;
  assign cnt_m1 = cnt_q - 1'b1;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    init_d   = init_q;
    lkp_en   = 1'b0;
    out_load = 1'b0;
    d_we     = 1'b0;
    d_re     = 1'b0;
    d_waddr  = {set_q, way_q, cnt_m1[OFF_W-1:0]};
    d_raddr  = {set_q, way_q, cnt_q[OFF_W-1:0]};
    d_wdata  = m_rdata_q;
    m_we     = 1'b0;
    m_re     = 1'b0;
    m_waddr  = {vtag_q, set_q, cnt_m1[OFF_W-1:0]};
    m_raddr  = {tag_q, set_q, cnt_q[OFF_W-1:0]};
    m_wdata  = d_rdata_q;
    ctl_o            = '0;
    ctl_o.set        = take ? req_i.word_address[OFF_W +: SET_W] : set_q;
    ctl_o.rd_en      = take;
    ctl_o.way        = way_q;
    ctl_o.tag        = tag_q;
    unique case (state_q)
      ST_INIT: begin
        // backing memory preload: word i holds 4*i
        m_we    = 1'b1;
        m_waddr = init_q;
        m_wdata = DATA_W'({init_q, 2'b00});
        init_d  = init_q + 1'b1;
        if (&init_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        lkp_en = 1'b1;
        cnt_d  = '0;
        if (lkp_i.hit) begin
          state_d = ST_ACCESS;
        end else if (lkp_i.dirty_victim) begin
          state_d = ST_WB;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_WB: begin
        // read word k while word k-1 goes to memory
        d_re  = cnt_q != CNT_W'(LINE_WORDS);
        m_we  = cnt_q != '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LINE_WORDS)) begin
          cnt_d   = '0;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        m_re  = cnt_q != CNT_W'(LINE_WORDS);
        d_we  = cnt_q != '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(LINE_WORDS)) begin
          cnt_d      = '0;
          ctl_o.fill = 1'b1;
          state_d    = ST_ACCESS;
        end
      end
      ST_ACCESS: begin
        d_raddr     = {set_q, way_q, off_q};
        d_waddr     = {set_q, way_q, off_q};
        d_wdata     = wdata_q;
        m_waddr     = {tag_q, set_q, off_q};
        m_wdata     = wdata_q;
        ctl_o.touch = 1'b1;
        if (op_q == OP_READ) begin
          d_re = 1'b1;
        end else begin
          d_we = 1'b1;
          if (wt_q) begin
            m_we = 1'b1;
          end else begin
            ctl_o.mark_dirty = 1'b1;
          end
        end
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = state_q == ST_IDLE;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      cnt_q       <= '0;
      init_q      <= '0;
      wt_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      init_q      <= init_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        wt_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      op_q    <= req_i.operation;
      tag_q   <= req_i.word_address[OFF_W+SET_W +: TAG_W];
      set_q   <= req_i.word_address[OFF_W +: SET_W];
      off_q   <= req_i.word_address[OFF_W-1:0];
      wdata_q <= req_i.write_data;
    end
    if (lkp_en) begin
      hit_q   <= lkp_i.hit;
      way_q   <= lkp_i.way;
      evict_q <= lkp_i.evict;
      wb_q    <= lkp_i.dirty_victim;
      vtag_q  <= lkp_i.victim_tag;
    end
    if (out_load) begin
      out_data_q  <= (op_q == OP_READ) ? d_rdata_q : '0;
      out_hit_q   <= hit_q;
      out_evict_q <= evict_q;
      out_wb_q    <= wb_q;
      out_way_q   <= way_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_data  = out_data_q;
  assign rsp_o.hit        = out_hit_q;
  assign rsp_o.evicted    = out_evict_q;
  assign rsp_o.wrote_back = out_wb_q;
  assign rsp_o.way_used   = out_way_q;

endmodule

// ===== rtl/set_assoc_lru_cache.sv =====
// Top level of the set-associative LRU word cache with backing memory.
//
// Usage: word reads and writes arrive on req_i (valid/ready), one result
// item per request leaves on rsp_o (valid/ready). cfg_we_i/cfg_wdata_i
// set the write-through bit (0 = write-back); write it only while idle.
// A hit passes from accept through the lookup, data access and result
// steps; the tag row is read at the accept edge. A clean miss adds a line
// fill before the data access; a dirty miss also copies the victim back
// first. Both moves run one word a cycle through the read port of one
// memory and the write port of the other.
// One item is in flight at a time; the next is accepted once the result
// sits in the output register, so a stalled receiver holds at most one
// finished result plus the one being worked on.
// After reset the backing memory is preloaded (word i = 4*i) in a pass
// over all MEM_WORDS (4096) words with req_i.ready low; valid and dirty
// bits clear at once and the LRU order resets to way order.
`timescale 1ns / 1ps
module set_assoc_lru_cache
  import sacl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  sacl_req_if.sink   req_i,
  sacl_rsp_if.source rsp_o
);

  lookup_t  lkp;
  tag_ctl_t ctl;

  sacl_tags u_tags (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .lkp_o  (lkp)
  );

  sacl_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i),
    .rsp_o       (rsp_o),
    .lkp_i       (lkp),
    .ctl_o       (ctl)
  );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for the set-associative LRU cache: predictor, driver, monitor, checks.
`timescale 1ns / 1ps
module tb_top;
  import sacl_pkg::*;

  typedef struct packed {
    logic                     operation;
    logic [ADDR_W-1:0]        word_address;
    logic [DATA_W-1:0]        write_data;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              hit;
    logic              evicted;
    logic              wrote_back;
    logic [WAY_W-1:0]  way_used;
  } outcome_t;

  localparam int QUIET_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  sacl_req_if req_if ();
  sacl_rsp_if rsp_if ();

  set_assoc_lru_cache DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .rsp_o      (rsp_if.source)
  );

  // predictor state
  logic              wt_mode;
  logic [TAG_W-1:0]  p_tag [NLINES];
  logic              p_valid [NLINES];
  logic              p_dirty [NLINES];
  int                p_order [NUM_SETS][WAYS];
  logic [DATA_W-1:0] p_line [NLINES*LINE_WORDS];
  logic [DATA_W-1:0] p_mem [MEM_WORDS];

  access_t  pending_q [$];
  outcome_t expected_q [$];

  int  n_errors = 0;
  int  n_results = 0;
  int  n_hits = 0;
  int  n_wbacks = 0;
  int  quiet_cycles = 0;
  logic driving_done = 1'b0;
  logic idle_off = 1'b0;
  int  hold_cycles = 0;

  function automatic void predictor_reset();
    for (int l = 0; l < NLINES; l++) begin
      p_valid[l] = 1'b0;
      p_dirty[l] = 1'b0;
      p_tag[l] = '0;
    end
    for (int s = 0; s < NUM_SETS; s++)
      for (int w = 0; w < WAYS; w++) p_order[s][w] = w;
    for (int i = 0; i < MEM_WORDS; i++) p_mem[i] = DATA_W'(i * 4);
    for (int i = 0; i < NLINES*LINE_WORDS; i++) p_line[i] = '0;
  endfunction

  function automatic outcome_t cache_access(access_t a);
    outcome_t r;
    int tag, set, off, way, line, pos, vbase, base;
    logic found, freef;
    tag = a.word_address / (NUM_SETS*LINE_WORDS);
    set = (a.word_address / LINE_WORDS) % NUM_SETS;
    off = a.word_address % LINE_WORDS;
    r = '0;
    way = 0;
    found = 1'b0;
    for (int k = 0; k < WAYS; k++)
      if (!found && p_valid[set*WAYS+k] && p_tag[set*WAYS+k] == tag) begin
        way = k;
        found = 1'b1;
      end
    if (found) begin
      r.hit = 1'b1;
    end else begin
      freef = 1'b0;
      for (int k = 0; k < WAYS; k++)
        if (!freef && !p_valid[set*WAYS+k]) begin
          way = k;
          freef = 1'b1;
        end
      if (!freef) way = p_order[set][WAYS-1];
      line = set*WAYS + way;
      if (p_valid[line]) begin
        r.evicted = 1'b1;
        if (p_dirty[line]) begin
          r.wrote_back = 1'b1;
          vbase = (p_tag[line]*NUM_SETS + set) * LINE_WORDS;
          for (int k = 0; k < LINE_WORDS; k++)
            p_mem[(vbase+k) % MEM_WORDS] = p_line[line*LINE_WORDS+k];
        end
      end
      base = a.word_address - off;
      for (int k = 0; k < LINE_WORDS; k++)
        p_line[line*LINE_WORDS+k] = p_mem[(base+k) % MEM_WORDS];
      p_tag[line] = TAG_W'(tag);
      p_valid[line] = 1'b1;
      p_dirty[line] = 1'b0;
    end
    line = set*WAYS + way;
    if (a.operation == OP_READ) begin
      r.read_data = p_line[line*LINE_WORDS+off];
    end else begin
      p_line[line*LINE_WORDS+off] = a.write_data;
      if (wt_mode) p_mem[a.word_address % MEM_WORDS] = a.write_data;
      else p_dirty[line] = 1'b1;
    end
    pos = WAYS-1;
    for (int i = WAYS-1; i >= 0; i--)
      if (p_order[set][i] == way) pos = i;
    for (int i = pos; i > 0; i--) p_order[set][i] = p_order[set][i-1];
    p_order[set][0] = way;
    r.way_used = WAY_W'(way);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    n_errors++;
    $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic access_t make_access(logic op, int addr, logic [DATA_W-1:0] d);
    access_t a;
    a.operation = op;
    a.word_address = ADDR_W'(addr);
    a.write_data = d;
    return a;
  endfunction

  function automatic void queue_item(access_t a);
    pending_q.insert(pending_q.size(), a);
  endfunction

  // addresses in a few sets with a handful of tags, so sets fill and evict
  function automatic access_t random_access();
    int addr;
    if ($urandom_range(0, 9) < 8)
      addr = $urandom_range(0, 5) * (NUM_SETS*LINE_WORDS)
           + $urandom_range(0, 3) * LINE_WORDS + $urandom_range(0, LINE_WORDS-1);
    else
      addr = $urandom_range(0, MEM_WORDS-1);
    return make_access(1'($urandom_range(0, 1)), addr, $urandom());
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= 1'b0;
      req_if.word_address <= '0;
      req_if.write_data <= '0;
    end else begin
      if (!req_if.valid || req_if.ready) begin
        if (req_if.valid) expected_q.insert(expected_q.size(),
          cache_access({req_if.operation, req_if.word_address, req_if.write_data}));
        if (pending_q.size() > 0 && (idle_off || $urandom_range(0, 99) >= 8)) begin
          access_t a;
          a = pending_q.pop_front();
          req_if.valid <= 1'b1;
          req_if.operation <= a.operation;
          req_if.word_address <= a.word_address;
          req_if.write_data <= a.write_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= idle_off || ($urandom_range(0, 99) >= 8);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", rsp_if.read_data, '0);
        end else begin
          outcome_t e;
          e = expected_q.pop_front();
          n_results++;
          if (e.hit) n_hits++;
          if (e.wrote_back) n_wbacks++;
          if (rsp_if.read_data !== e.read_data)
            report_mismatch("read_data", rsp_if.read_data, e.read_data);
          if (rsp_if.hit !== e.hit)
            report_mismatch("hit", DATA_W'(rsp_if.hit), DATA_W'(e.hit));
          if (rsp_if.evicted !== e.evicted)
            report_mismatch("evicted", DATA_W'(rsp_if.evicted), DATA_W'(e.evicted));
          if (rsp_if.wrote_back !== e.wrote_back)
            report_mismatch("wrote_back", DATA_W'(rsp_if.wrote_back),
                            DATA_W'(e.wrote_back));
          if (rsp_if.way_used !== e.way_used)
            report_mismatch("way_used", DATA_W'(rsp_if.way_used), DATA_W'(e.way_used));
        end
      end
      if (quiet_cycles > QUIET_LIMIT) begin
        $display("timeout: nothing accepted for %0d cycles", QUIET_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_q.size() > 0 || req_if.valid || expected_q.size() > 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_policy(logic wt);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= wt;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    wt_mode = wt;
  endtask

  initial begin
    int stride;
    stride = NUM_SETS*LINE_WORDS;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    wt_mode = 1'b0;
    predictor_reset();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, write-back: address extremes, dirty eviction, all ways of a set
    set_policy(1'b0);
    queue_item(make_access(OP_READ, 0, '0));
    queue_item(make_access(OP_WRITE, 0, 32'hFFFF_FFFF));
    queue_item(make_access(OP_READ, 0, '0));
    queue_item(make_access(OP_READ, MEM_WORDS-1, 32'hFFFF_FFFF));
    queue_item(make_access(OP_WRITE, MEM_WORDS-1, 32'h0));
    for (int t = 1; t <= 5; t++)
      queue_item(make_access(OP_WRITE, t*stride + 3, 32'hA5A5_0000 + t));
    queue_item(make_access(OP_READ, 3, '0));
    queue_item(make_access(OP_READ, stride + 3, '0));
    wait_drained();

    // write-through with lines still dirty
    set_policy(1'b1);
    for (int t = 0; t < 6; t++)
      queue_item(make_access(1'(t % 2), t*stride + 3, 32'h5A5A_0000 + t));
    queue_item(make_access(OP_WRITE, 7*stride + 15, 32'h8000_0001));
    queue_item(make_access(OP_READ, 7*stride + 15, '0));
    wait_drained();

    // random phases, alternating policy; first phase has no idling
    for (int ph = 0; ph < 6; ph++) begin
      set_policy(1'(ph % 2));
      idle_off = (ph == 0);
      for (int i = 0; i < 250; i++) queue_item(random_access());
      if (ph == 2) begin
        @(posedge clk_i);
        hold_cycles <= 400;
      end
      wait_drained();
    end
    $display("Ran %0d accesses: %0d hits, %0d write-backs, both write policies.",
             n_results, n_hits, n_wbacks);
    if (n_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
